// ===== hw/rtl/bfr_pkg.sv =====
// shared types, constants and helper functions of the bitmap font text renderer
`timescale 1ns / 1ps

package bfr_pkg;

   localparam int GLYPH_STORE_BYTES = 4096;
   localparam int GLYPH_ROWS        = 16;
   localparam int MAX_SURFACE_DIM   = 1024;

   localparam int STORE_AW = $clog2(GLYPH_STORE_BYTES);
   localparam int GADDR_W  = 12;
   localparam int ROWS_W   = $clog2(GLYPH_ROWS + 1);
   localparam int DIM_W    = 11;
   localparam int CURSOR_W = 11;
   localparam int MUL_W    = 11;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int ADDR_W   = 22;
   localparam int PIX_W    = 8;
   localparam int COLOR_W  = 32;

   localparam logic [CURSOR_W-1:0] CURSOR_MAX   = 11'd2047;
   localparam logic [7:0]          NEWLINE_CODE = 8'd10;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_CURSOR = 2'd1;
   localparam logic [1:0] OP_DRAW   = 2'd2;

   localparam logic [2:0] REG_CHAR_WIDTH     = 3'd0;
   localparam logic [2:0] REG_CHAR_HEIGHT    = 3'd1;
   localparam logic [2:0] REG_SURFACE_WIDTH  = 3'd2;
   localparam logic [2:0] REG_SURFACE_HEIGHT = 3'd3;
   localparam logic [2:0] REG_INK_COLOR      = 3'd4;
   localparam logic [2:0] REG_PAPER_COLOR    = 3'd5;

   typedef struct packed {
      logic [3:0]         char_width;
      logic [4:0]         char_height;
      logic [DIM_W-1:0]   surface_width;
      logic [DIM_W-1:0]   surface_height;
      logic [COLOR_W-1:0] ink_color;
      logic [COLOR_W-1:0] paper_color;
   } cfg_type;

   typedef struct packed {
      logic                en;
      logic [STORE_AW-1:0] addr;
      logic [7:0]          data;
   } ram_wr_type;

   typedef struct packed {
      logic                en;
      logic [STORE_AW-1:0] addr;
   } ram_rd_type;

   function automatic logic [CURSOR_W-1:0] sat_cursor(input logic [PROD_W-1:0] v);
      return (v > PROD_W'(CURSOR_MAX)) ? CURSOR_MAX : v[CURSOR_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/bitmap_font_text_renderer_top.sv =====
// bitmap font text renderer top level: register file and unit wiring
//
// Request items carry an operation: load one glyph store byte, set the cursor
// to a character cell, or draw a character code (code 10 is a newline).
// Load and newline items finish in the cycle they are taken; set cursor keeps
// the request side stalled through S_SETX, S_SETY and S_SETD. A printable
// character keeps it stalled through S_WRAP, S_BASE, S_ADDR and S_ROW, the
// last emitting rows items, rows being char_height capped at 16: the shared
// multiplier computes the surface size and the row base address, then the
// glyph RAM read port delivers one row per cycle while the output is not
// stalled, the final row flagged with rsp_last. When the receiver stalls, the
// output register holds its item and row emission pauses; a new request is
// taken while the final row waits. Reset clears the cursor, empties the output
// register and loads the register defaults; the glyph store is not cleared
// and must be loaded before use. Registers must be written by the user through
// the APB port only while idle; the block itself does not enforce this.
`timescale 1ns / 1ps

module bitmap_font_text_renderer_top import bfr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_operation,
   input  logic [11:0]         req_glyph_index,
   input  logic [7:0]          req_glyph_byte,
   input  logic [9:0]          req_start_col,
   input  logic [9:0]          req_start_row,
   input  logic [7:0]          req_char_code,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [21:0]         rsp_row_address,
   output logic [7:0]          rsp_fg_bits,
   output logic [7:0]          rsp_write_mask,
   output logic [31:0]         rsp_foreground_color,
   output logic [31:0]         rsp_background_color,
   output logic                rsp_last,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [4:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   cfg_type           cfg_ff, cfg_in;
   logic [2:0]        reg_sel;
   ram_wr_type        ram_wr;
   ram_rd_type        ram_rd;
   logic [7:0]        ram_rd_data;
   logic [MUL_W-1:0]  mul_a, mul_b;
   logic [PROD_W-1:0] mul_p;

   assign pready  = 1'b1;
   assign reg_sel = paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         case (reg_sel)
            REG_CHAR_WIDTH:     cfg_in.char_width     = pwdata[3:0];
            REG_CHAR_HEIGHT:    cfg_in.char_height    = pwdata[4:0];
            REG_SURFACE_WIDTH:  cfg_in.surface_width  = pwdata[DIM_W-1:0];
            REG_SURFACE_HEIGHT: cfg_in.surface_height = pwdata[DIM_W-1:0];
            REG_INK_COLOR:      cfg_in.ink_color      = pwdata;
            REG_PAPER_COLOR:    cfg_in.paper_color    = pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_CHAR_WIDTH:     prdata = 32'(cfg_ff.char_width);
         REG_CHAR_HEIGHT:    prdata = 32'(cfg_ff.char_height);
         REG_SURFACE_WIDTH:  prdata = 32'(cfg_ff.surface_width);
         REG_SURFACE_HEIGHT: prdata = 32'(cfg_ff.surface_height);
         REG_INK_COLOR:      prdata = cfg_ff.ink_color;
         REG_PAPER_COLOR:    prdata = cfg_ff.paper_color;
         default:            prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.char_width     <= 4'd8;
         cfg_ff.char_height    <= 5'd16;
         cfg_ff.surface_width  <= 11'd640;
         cfg_ff.surface_height <= 11'd480;
         cfg_ff.ink_color      <= 32'hFFFF_FFFF;
         cfg_ff.paper_color    <= 32'h0000_0000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bfr_ctrl u_ctrl (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg_ff),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_operation        (req_operation),
      .req_glyph_index      (req_glyph_index),
      .req_glyph_byte       (req_glyph_byte),
      .req_start_col        (req_start_col),
      .req_start_row        (req_start_row),
      .req_char_code        (req_char_code),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_row_address      (rsp_row_address),
      .rsp_fg_bits          (rsp_fg_bits),
      .rsp_write_mask       (rsp_write_mask),
      .rsp_foreground_color (rsp_foreground_color),
      .rsp_background_color (rsp_background_color),
      .rsp_last             (rsp_last),
      .ram_wr               (ram_wr),
      .ram_rd               (ram_rd),
      .ram_rd_data          (ram_rd_data),
      .mul_a                (mul_a),
      .mul_b                (mul_b),
      .mul_p                (mul_p)
   );

   bfr_glyph_ram u_glyph_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd      (ram_rd),
      .rd_data (ram_rd_data)
   );

   bfr_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

endmodule

// ===== hw/rtl/bfr_glyph_ram.sv =====
// glyph store memory, one write port and one registered read port
`timescale 1ns / 1ps

module bfr_glyph_ram import bfr_pkg::*; (
   input  logic       clock,
   input  ram_wr_type wr,
   input  ram_rd_type rd,
   output logic [7:0] rd_data
);

   logic [7:0] glyph_mem_ff [GLYPH_STORE_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         glyph_mem_ff[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= glyph_mem_ff[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/bfr_mul.sv =====
// shared multiplier with registered product
`timescale 1ns / 1ps

module bfr_mul import bfr_pkg::*; (
   input  logic              clock,
   input  logic [MUL_W-1:0]  op_a,
   input  logic [MUL_W-1:0]  op_b,
   output logic [PROD_W-1:0] product
);

   logic [PROD_W-1:0] product_ff;

   always_ff @(posedge clock) begin
      product_ff <= op_a * op_b;
   end

   assign product = product_ff;

endmodule

// ===== hw/rtl/bfr_ctrl.sv =====
// sequencer: cursor state, multiplier scheduling, glyph row emission
`timescale 1ns / 1ps

module bfr_ctrl import bfr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_operation,
   input  logic [GADDR_W-1:0]  req_glyph_index,
   input  logic [7:0]          req_glyph_byte,
   input  logic [9:0]          req_start_col,
   input  logic [9:0]          req_start_row,
   input  logic [7:0]          req_char_code,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [ADDR_W-1:0]   rsp_row_address,
   output logic [PIX_W-1:0]    rsp_fg_bits,
   output logic [PIX_W-1:0]    rsp_write_mask,
   output logic [COLOR_W-1:0]  rsp_foreground_color,
   output logic [COLOR_W-1:0]  rsp_background_color,
   output logic                rsp_last,
   output ram_wr_type          ram_wr,
   output ram_rd_type          ram_rd,
   input  logic [7:0]          ram_rd_data,
   output logic [MUL_W-1:0]    mul_a,
   output logic [MUL_W-1:0]    mul_b,
   input  logic [PROD_W-1:0]   mul_p
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SETX = 3'd1;
   localparam logic [2:0] S_SETY = 3'd2;
   localparam logic [2:0] S_SETD = 3'd3;
   localparam logic [2:0] S_WRAP = 3'd4;
   localparam logic [2:0] S_BASE = 3'd5;
   localparam logic [2:0] S_ADDR = 3'd6;
   localparam logic [2:0] S_ROW  = 3'd7;

   logic [2:0]          state_ff, state_in;
   logic [CURSOR_W-1:0] cursor_x_ff, cursor_x_in;
   logic [CURSOR_W-1:0] cursor_y_ff, cursor_y_in;
   logic [9:0]          col_ff, col_in;
   logic [9:0]          row_cell_ff, row_cell_in;
   logic [GADDR_W-1:0]  gbase_ff, gbase_in;
   logic [ADDR_W-1:0]   limit_ff, limit_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [ROWS_W-1:0]   row_ff, row_in;
   logic                rd_ok_ff, rd_ok_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]   rsp_row_address_ff, rsp_row_address_in;
   logic [PIX_W-1:0]    rsp_fg_bits_ff, rsp_fg_bits_in;
   logic [PIX_W-1:0]    rsp_write_mask_ff, rsp_write_mask_in;
   logic [COLOR_W-1:0]  rsp_ink_color_ff, rsp_ink_color_in;
   logic [COLOR_W-1:0]  rsp_paper_color_ff, rsp_paper_color_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [DIM_W-1:0]    tx, ty;
   logic [3:0]          draw_w;
   logic [ROWS_W-1:0]   rows;
   logic                accept, out_free, is_last, wrap, in_limit;
   logic [CURSOR_W-1:0] cy_step, cy_wrapped, cx_step;
   logic [GADDR_W-1:0]  rd_full;
   logic [ADDR_W-1:0]   remain;
   logic [7:0]          glyph_bits;
   logic [PIX_W-1:0]    fg_row, mask_row;
   logic [3:0]          bit_sel;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign tx = (cfg.surface_width > DIM_W'(MAX_SURFACE_DIM)) ?
               DIM_W'(MAX_SURFACE_DIM) : cfg.surface_width;
   assign ty = (cfg.surface_height > DIM_W'(MAX_SURFACE_DIM)) ?
               DIM_W'(MAX_SURFACE_DIM) : cfg.surface_height;
   assign draw_w = (cfg.char_width > 4'(PIX_W)) ? 4'(PIX_W) : cfg.char_width;
   assign rows = (cfg.char_height > 5'(GLYPH_ROWS)) ?
                 ROWS_W'(GLYPH_ROWS) : ROWS_W'(cfg.char_height);
   assign is_last = (row_ff == ROWS_W'(rows - ROWS_W'(1)));

   assign cy_step = sat_cursor(PROD_W'(cursor_y_ff) + PROD_W'(cfg.char_height));
   assign cx_step = sat_cursor(PROD_W'(cursor_x_ff) + PROD_W'(cfg.char_width));
   assign wrap    = (cursor_x_ff >= tx);
   assign cy_wrapped = wrap ? cy_step : cursor_y_ff;

   // glyph row pixels and surface mask
   assign glyph_bits = rd_ok_ff ? ram_rd_data : 8'd0;
   assign in_limit   = (addr_ff < limit_ff);
   assign remain     = limit_ff - addr_ff;

   always_comb begin
      bit_sel  = 4'd0;
      fg_row   = '0;
      mask_row = '0;
      for (int i = 0; i < PIX_W; i++) begin
         bit_sel = draw_w - 4'(i) - 4'd1;
         if (4'(i) < draw_w) begin
            fg_row[i]   = glyph_bits[bit_sel[2:0]];
            mask_row[i] = in_limit && (ADDR_W'(i) < remain);
         end
      end
   end

   // multiplier operand schedule
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_SETX: begin
            mul_a = MUL_W'(col_ff);
            mul_b = MUL_W'(cfg.char_width);
         end
         S_SETY: begin
            mul_a = MUL_W'(row_cell_ff);
            mul_b = MUL_W'(cfg.char_height);
         end
         S_WRAP: begin
            mul_a = MUL_W'(tx);
            mul_b = MUL_W'(ty);
         end
         S_BASE: begin
            mul_a = MUL_W'(tx);
            mul_b = MUL_W'(cursor_y_ff);
         end
         default: begin
         end
      endcase
   end

   assign rd_full = (state_ff == S_ROW) ?
                    GADDR_W'(gbase_ff + GADDR_W'(row_ff) + GADDR_W'(1)) : gbase_ff;

   always_comb begin
      state_in    = state_ff;
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      col_in      = col_ff;
      row_cell_in = row_cell_ff;
      gbase_in    = gbase_ff;
      limit_in    = limit_ff;
      addr_in     = addr_ff;
      row_in      = row_ff;
      rd_ok_in    = rd_ok_ff;

      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_row_address_in = rsp_row_address_ff;
      rsp_fg_bits_in     = rsp_fg_bits_ff;
      rsp_write_mask_in  = rsp_write_mask_ff;
      rsp_ink_color_in   = rsp_ink_color_ff;
      rsp_paper_color_in = rsp_paper_color_ff;
      rsp_last_in        = rsp_last_ff;

      ram_wr.en   = 1'b0;
      ram_wr.addr = req_glyph_index[STORE_AW-1:0];
      ram_wr.data = req_glyph_byte;
      ram_rd.en   = 1'b0;
      ram_rd.addr = rd_full[STORE_AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               col_in      = req_start_col;
               row_cell_in = req_start_row;
               gbase_in    = req_char_code[7] ? '0 :
                             GADDR_W'(req_char_code[6:0] * GLYPH_ROWS);
               case (req_operation)
                  OP_LOAD: begin
                     ram_wr.en = ({1'b0, req_glyph_index} < (GADDR_W + 1)'(GLYPH_STORE_BYTES));
                  end
                  OP_CURSOR: begin
                     state_in = S_SETX;
                  end
                  OP_DRAW: begin
                     if (req_char_code == NEWLINE_CODE) begin
                        cursor_y_in = cy_step;
                     end else begin
                        state_in = S_WRAP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SETX: begin
            state_in = S_SETY;
         end
         S_SETY: begin
            cursor_x_in = sat_cursor(mul_p);
            state_in    = S_SETD;
         end
         S_SETD: begin
            cursor_y_in = sat_cursor(mul_p);
            state_in    = S_IDLE;
         end
         S_WRAP: begin
            if (wrap) begin
               cursor_x_in = '0;
            end
            cursor_y_in = (cy_wrapped >= ty) ? '0 : cy_wrapped;
            state_in    = S_BASE;
         end
         S_BASE: begin
            limit_in  = ADDR_W'(mul_p);
            ram_rd.en = 1'b1;
            rd_ok_in  = ({1'b0, rd_full} < (GADDR_W + 1)'(GLYPH_STORE_BYTES));
            state_in  = S_ADDR;
         end
         S_ADDR: begin
            addr_in = ADDR_W'(mul_p) + ADDR_W'(cursor_x_ff);
            row_in  = '0;
            if (rows == '0) begin
               cursor_x_in = cx_step;
               state_in    = S_IDLE;
            end else begin
               state_in = S_ROW;
            end
         end
         S_ROW: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_row_address_in = addr_ff;
               rsp_fg_bits_in     = fg_row;
               rsp_write_mask_in  = mask_row;
               rsp_ink_color_in   = cfg.ink_color;
               rsp_paper_color_in = cfg.paper_color;
               rsp_last_in        = is_last;
               if (is_last) begin
                  cursor_x_in = cx_step;
                  state_in    = S_IDLE;
               end else begin
                  row_in    = ROWS_W'(row_ff + ROWS_W'(1));
                  addr_in   = addr_ff + ADDR_W'(tx);
                  ram_rd.en = 1'b1;
                  rd_ok_in  = ({1'b0, rd_full} < (GADDR_W + 1)'(GLYPH_STORE_BYTES));
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cursor_x_ff  <= '0;
         cursor_y_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff             <= col_in;
      row_cell_ff        <= row_cell_in;
      gbase_ff           <= gbase_in;
      limit_ff           <= limit_in;
      addr_ff            <= addr_in;
      row_ff             <= row_in;
      rd_ok_ff           <= rd_ok_in;
      rsp_row_address_ff <= rsp_row_address_in;
      rsp_fg_bits_ff     <= rsp_fg_bits_in;
      rsp_write_mask_ff  <= rsp_write_mask_in;
      rsp_ink_color_ff   <= rsp_ink_color_in;
      rsp_paper_color_ff <= rsp_paper_color_in;
      rsp_last_ff        <= rsp_last_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_row_address      = rsp_row_address_ff;
   assign rsp_fg_bits          = rsp_fg_bits_ff;
   assign rsp_write_mask       = rsp_write_mask_ff;
   assign rsp_foreground_color = rsp_ink_color_ff;
   assign rsp_background_color = rsp_paper_color_ff;
   assign rsp_last             = rsp_last_ff;

endmodule

// ===== hw/rtl/bfr_checker.sv =====
// port level assertions for the bitmap font text renderer, bound to the top
`timescale 1ns / 1ps

module bfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [21:0] rsp_row_address,
   input logic [7:0]  rsp_fg_bits,
   input logic [7:0]  rsp_write_mask,
   input logic        rsp_last
);

   // stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_row_address) &&
      $stable(rsp_fg_bits) && $stable(rsp_write_mask) && $stable(rsp_last))
      else $error("result item changed while stalled");

   // no result item right after reset
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a character's rows are still in flight, no new request is taken
   a_busy_mid_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("request side open while a character is being emitted");

   // rows of one character follow without a gap
   a_rows_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid)
      else $error("gap between glyph rows of one character");

endmodule

bind bitmap_font_text_renderer_top bfr_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_row_address (rsp_row_address),
   .rsp_fg_bits     (rsp_fg_bits),
   .rsp_write_mask  (rsp_write_mask),
   .rsp_last        (rsp_last)
);

// ===== test/bfr_text_checker.sv =====
// checker for the bitmap font text renderer: predicts glyph row items and compares them
`timescale 1ns / 1ps

module bfr_text_checker import bfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [11:0] req_glyph_index,
   input  logic [7:0]  req_glyph_byte,
   input  logic [9:0]  req_start_col,
   input  logic [9:0]  req_start_row,
   input  logic [7:0]  req_char_code,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [21:0] rsp_row_address,
   input  logic [7:0]  rsp_fg_bits,
   input  logic [7:0]  rsp_write_mask,
   input  logic [31:0] rsp_foreground_color,
   input  logic [31:0] rsp_background_color,
   input  logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          fail_count,
   output int          rows_outstanding
);

   typedef struct packed {
      logic [21:0] row_address;
      logic [7:0]  fg_bits;
      logic [7:0]  write_mask;
      logic [31:0] foreground_color;
      logic [31:0] background_color;
      logic        last;
   } glyph_row_type;

   glyph_row_type pending_rows[$];
   glyph_row_type oldest_row;
   logic [7:0]    glyph_copy [GLYPH_STORE_BYTES];
   int unsigned   pen_x;
   int unsigned   pen_y;
   cfg_type       cfg;

   function automatic int unsigned clip_cursor(input int unsigned v);
      return (v > CURSOR_MAX) ? int'(CURSOR_MAX) : v;
   endfunction

   function automatic void render_item(input logic [1:0] op, input logic [11:0] gidx,
                                       input logic [7:0] gbyte, input logic [9:0] col,
                                       input logic [9:0] row, input logic [7:0] code);
      int unsigned   tx, ty, limit, w, nrows, base, addr, i, j;
      logic [7:0]    bits;
      glyph_row_type row_item;
      case (op)
         OP_LOAD: glyph_copy[gidx] = gbyte;
         OP_CURSOR: begin
            pen_x = clip_cursor(32'(col) * cfg.char_width);
            pen_y = clip_cursor(32'(row) * cfg.char_height);
         end
         OP_DRAW: begin
            if (code == NEWLINE_CODE) begin
               pen_y = clip_cursor(pen_y + cfg.char_height);
            end else begin
               tx = (cfg.surface_width > MAX_SURFACE_DIM) ? MAX_SURFACE_DIM : cfg.surface_width;
               ty = (cfg.surface_height > MAX_SURFACE_DIM) ? MAX_SURFACE_DIM
                                                           : cfg.surface_height;
               limit = tx * ty;
               w = (cfg.char_width > 8) ? 8 : cfg.char_width;
               nrows = (cfg.char_height > GLYPH_ROWS) ? GLYPH_ROWS : cfg.char_height;
               base = code[7] ? 0 : 32'(code) * GLYPH_ROWS;
               if (pen_x >= tx) begin
                  pen_x = 0;
                  pen_y = clip_cursor(pen_y + cfg.char_height);
               end
               if (pen_y >= ty) pen_y = 0;
               for (j = 0; j < nrows; j++) begin
                  addr = tx * (pen_y + j) + pen_x;
                  bits = glyph_copy[base + j];
                  row_item = '0;
                  for (i = 0; i < w; i++) begin
                     if (bits[w - 1 - i]) row_item.fg_bits[i] = 1'b1;
                     if (addr + i < limit) row_item.write_mask[i] = 1'b1;
                  end
                  row_item.row_address = addr[21:0];
                  row_item.foreground_color = cfg.ink_color;
                  row_item.background_color = cfg.paper_color;
                  row_item.last = (j + 1 == nrows);
                  pending_rows.push_back(row_item);
               end
               pen_x = clip_cursor(pen_x + cfg.char_width);
            end
         end
         default: ;
      endcase
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pending_rows.delete();
         pen_x = 0;
         pen_y = 0;
         cfg.char_width = 4'd8;
         cfg.char_height = 5'd16;
         cfg.surface_width = 11'd640;
         cfg.surface_height = 11'd480;
         cfg.ink_color = 32'hFFFF_FFFF;
         cfg.paper_color = 32'h0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               REG_CHAR_WIDTH:     cfg.char_width = pwdata[3:0];
               REG_CHAR_HEIGHT:    cfg.char_height = pwdata[4:0];
               REG_SURFACE_WIDTH:  cfg.surface_width = pwdata[10:0];
               REG_SURFACE_HEIGHT: cfg.surface_height = pwdata[10:0];
               REG_INK_COLOR:      cfg.ink_color = pwdata;
               REG_PAPER_COLOR:    cfg.paper_color = pwdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            render_item(req_operation, req_glyph_index, req_glyph_byte, req_start_col,
                        req_start_row, req_char_code);
         if (rsp_valid && !rsp_stall) begin
            if (pending_rows.size() == 0) begin
               $error("result item with no expectation waiting, row_address %0h",
                      rsp_row_address);
               fail_count++;
            end else begin
               oldest_row = pending_rows.pop_front();
               compare_field("row_address", oldest_row.row_address, rsp_row_address);
               compare_field("fg_bits", oldest_row.fg_bits, rsp_fg_bits);
               compare_field("write_mask", oldest_row.write_mask, rsp_write_mask);
               compare_field("foreground_color", oldest_row.foreground_color,
                             rsp_foreground_color);
               compare_field("background_color", oldest_row.background_color,
                             rsp_background_color);
               compare_field("last", oldest_row.last, rsp_last);
            end
         end
      end
      rows_outstanding = pending_rows.size();
   end

endmodule

// ===== test/bitmap_font_text_renderer_top_tb.sv =====
// testbench top for the bitmap font text renderer: stimulus, handshake pacing and verdict
`timescale 1ns / 1ps

module bitmap_font_text_renderer_top_tb import bfr_pkg::*; ();

   localparam int         CYCLE_LIMIT    = 2_000_000;
   localparam int         SEG_ITEMS      = 43;
   localparam int         SETTLE_CYCLES  = 24;
   localparam int         HOLDOFF_CYCLES = 300;
   localparam int         TAIL_CYCLES    = 30;
   localparam logic [1:0] OP_UNUSED      = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = OP_LOAD;
   logic [11:0] req_glyph_index = '0;
   logic [7:0]  req_glyph_byte = '0;
   logic [9:0]  req_start_col = '0;
   logic [9:0]  req_start_row = '0;
   logic [7:0]  req_char_code = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [21:0] rsp_row_address;
   logic [7:0]  rsp_fg_bits;
   logic [7:0]  rsp_write_mask;
   logic [31:0] rsp_foreground_color;
   logic [31:0] rsp_background_color;
   logic        rsp_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   int   fail_count;
   int   rows_outstanding;
   int   cycle_count = 0;
   int   send_idle_pct = 36;
   int   recv_idle_pct = 64;
   logic holdoff_active = 1'b0;
   event holdoff_go;

   int         cur_cw = 8;
   int         cur_ch = 16;
   int         cur_sw = 640;
   int         cur_sh = 480;
   bit         glyph_written [GLYPH_STORE_BYTES];
   logic [7:0] ready_codes[$];

   bitmap_font_text_renderer_top dut (.*);

   bfr_text_checker checker_i (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_stall <= holdoff_active || ($urandom_range(99) < recv_idle_pct);

   initial forever begin
      @(holdoff_go);
      @(posedge clock);
      holdoff_active = 1'b1;
      repeat (HOLDOFF_CYCLES) @(posedge clock);
      holdoff_active = 1'b0;
   end

   task automatic send_item(input logic [1:0] op, input logic [11:0] gidx,
                            input logic [7:0] gbyte, input logic [9:0] col,
                            input logic [9:0] row, input logic [7:0] code);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_glyph_index <= gidx;
      req_glyph_byte <= gbyte;
      req_start_col <= col;
      req_start_row <= row;
      req_char_code <= code;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic load_byte(input logic [11:0] idx, input logic [7:0] value);
      glyph_written[idx] = 1'b1;
      send_item(OP_LOAD, idx, value, 10'($urandom), 10'($urandom), 8'($urandom));
   endtask

   task automatic drain(input int settle);
      req_valid <= 1'b0;
      wait (rows_outstanding == 0);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic apply_settings(input int cw, input int ch, input int sw, input int sh,
                                 input logic [31:0] fg, input logic [31:0] bg);
      drain(SETTLE_CYCLES);
      write_reg(REG_CHAR_WIDTH, 32'(cw));
      write_reg(REG_CHAR_HEIGHT, 32'(ch));
      write_reg(REG_SURFACE_WIDTH, 32'(sw));
      write_reg(REG_SURFACE_HEIGHT, 32'(sh));
      write_reg(REG_INK_COLOR, fg);
      write_reg(REG_PAPER_COLOR, bg);
      cur_cw = cw;
      cur_ch = ch;
      cur_sw = sw;
      cur_sh = sh;
   endtask

   function automatic bit glyph_ready(input logic [7:0] code);
      int unsigned base, nrows, j;
      base = code[7] ? 0 : 32'(code) * GLYPH_ROWS;
      nrows = (cur_ch > GLYPH_ROWS) ? GLYPH_ROWS : cur_ch;
      for (j = 0; j < nrows; j++)
         if (!glyph_written[base + j]) return 1'b0;
      return 1'b1;
   endfunction

   task automatic random_step(output int n_items);
      logic [11:0] gidx;
      logic [7:0]  gbyte, code, gcode;
      logic [9:0]  col, row;
      int unsigned pick, lim;
      int          k;
      gidx = 12'($urandom);
      gbyte = 8'($urandom);
      col = 10'($urandom);
      row = 10'($urandom);
      code = 8'($urandom);
      pick = $urandom_range(99);
      n_items = 1;
      if (pick < 6) begin
         // full glyph: 16 row bytes of one code
         gcode = 8'($urandom_range(1, 127));
         for (k = 0; k < GLYPH_ROWS; k++)
            load_byte(12'(32'(gcode) * GLYPH_ROWS + k), 8'($urandom));
         if (gcode != NEWLINE_CODE) ready_codes.push_back(gcode);
         n_items = GLYPH_ROWS;
      end else if (pick < 14) begin
         load_byte(gidx, gbyte);
      end else if (pick < 24) begin
         if ($urandom_range(3) != 0) begin
            lim = cur_sw / cur_cw + 1;
            if (lim > 1023) lim = 1023;
            col = 10'($urandom_range(lim));
            lim = cur_sh / cur_ch + 1;
            if (lim > 1023) lim = 1023;
            row = 10'($urandom_range(lim));
         end
         send_item(OP_CURSOR, gidx, gbyte, col, row, code);
      end else if (pick < 34) begin
         send_item(OP_DRAW, gidx, gbyte, col, row, NEWLINE_CODE);
      end else if (pick < 37) begin
         send_item(OP_UNUSED, gidx, gbyte, col, row, code);
         n_items = 0;
      end else begin
         if ($urandom_range(9) < 4) code = ready_codes[$urandom_range(ready_codes.size() - 1)];
         if (code != NEWLINE_CODE && !glyph_ready(code))
            code = ready_codes[$urandom_range(ready_codes.size() - 1)];
         send_item(OP_DRAW, gidx, gbyte, col, row, code);
      end
   endtask

   initial begin
      int seg, count, n, k;
      bit paused;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (k = 0; k < GLYPH_ROWS; k++)
         load_byte(12'(k), (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : (k == 2) ? 8'h01 :
                           (k == 3) ? 8'h80 : 8'($urandom));
      ready_codes.push_back(8'd0);
      load_byte(12'hFFF, 8'hA5);
      send_item(OP_CURSOR, '0, '0, 10'd0, 10'd0, '0);
      send_item(OP_DRAW, '0, '0, '0, '0, 8'd0);
      send_item(OP_DRAW, '0, '0, '0, '0, 8'd255);
      send_item(OP_DRAW, '0, '0, '0, '0, NEWLINE_CODE);
      send_item(OP_CURSOR, '0, '0, 10'd1023, 10'd1023, '0);
      send_item(OP_DRAW, '0, '0, '0, '0, 8'd128);
      send_item(OP_CURSOR, '0, '0, 10'd79, 10'd29, '0);
      send_item(OP_DRAW, '0, '0, '0, '0, 8'd0);
      send_item(OP_DRAW, '0, '0, '0, '0, 8'd0);

      for (seg = 1; seg <= 6; seg++) begin
         if (seg == 3) begin
            send_idle_pct = 64;
            recv_idle_pct = 36;
         end else if (seg == 5) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (seg == 1)
            apply_settings(8, 16, 1024, 1024, 32'h0, 32'hFFFF_FFFF);
         else if (seg == 2)
            apply_settings(1, 1, 1, 1, $urandom, $urandom);
         else
            apply_settings($urandom_range(1, 8), $urandom_range(1, 16),
                           ($urandom_range(1) != 0) ? $urandom_range(1, 64)
                                                    : $urandom_range(1, 1024),
                           ($urandom_range(1) != 0) ? $urandom_range(1, 64)
                                                    : $urandom_range(1, 1024),
                           $urandom, $urandom);
         if (seg == 5) -> holdoff_go;
         count = 0;
         paused = 1'b0;
         while (count < SEG_ITEMS) begin
            if (seg == 3 && !paused && count >= SEG_ITEMS / 2) begin
               drain(1);
               paused = 1'b1;
            end
            random_step(n);
            count += n;
         end
      end

      drain(TAIL_CYCLES);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
